FILE: rtl/jnle_pkg.sv
// Shared types and constants for the node list extractor.
// Holds the channel payload structs, the parse phase and token enums and the
// command record that passes from the front end to the back end.
`default_nettype none

package jnle_pkg;

  localparam int unsigned ID_BITS     = 63;
  localparam int unsigned NODE_W      = 63;
  localparam int unsigned PROD_W      = ID_BITS + 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_O     = 8'h6f;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_S     = 8'h73;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_CLOSE = 8'h5d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_number;
    logic              list_closed;
    logic              value_saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_SEARCH,
    PH_N,
    PH_NO,
    PH_NOD,
    PH_NODE,
    PH_SKIP1,
    PH_SKIP2,
    PH_SKIP3,
    PH_FIRST,
    PH_LIST
  } phase_e;

  typedef enum logic [1:0] {
    TOK_IDLE,
    TOK_DIGITS,
    TOK_DONE
  } tok_e;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_EMIT,
    CMD_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       closed;
    logic       is_digit;
    logic       is_blank;
    logic [3:0] digit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/jnle_front.sv
// Front end: keyword matcher and byte classifier.
// Turns accepted bytes into token commands for the back end where the phase calls for one.
// Depends on jnle_pkg.
`default_nettype none

module jnle_front import jnle_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);

  phase_e     phase_q, phase_d;
  logic       accept;
  logic [7:0] b;
  logic       push;
  cmd_kind_e  kind;
  logic       closed;

  assign b          = in_item_i.text_byte;
  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_N:     phase_d = (b == CHAR_O) ? PH_NO  : ((b == CHAR_N) ? PH_N : PH_SEARCH);
        PH_NO:    phase_d = (b == CHAR_D) ? PH_NOD : ((b == CHAR_N) ? PH_N : PH_SEARCH);
        PH_NOD:   phase_d = (b == CHAR_E) ? PH_NODE : ((b == CHAR_N) ? PH_N : PH_SEARCH);
        PH_NODE:  phase_d = (b == CHAR_S) ? PH_SKIP1 : ((b == CHAR_N) ? PH_N : PH_SEARCH);
        PH_SKIP1: phase_d = PH_SKIP2;
        PH_SKIP2: phase_d = PH_SKIP3;
        PH_SKIP3: phase_d = PH_FIRST;
        PH_FIRST: phase_d = PH_LIST;
        PH_LIST:  phase_d = (b == CHAR_CLOSE) ? PH_SEARCH : PH_LIST;
        default:  phase_d = (b == CHAR_N) ? PH_N : PH_SEARCH;
      endcase
      if (in_item_i.final_byte) begin
        phase_d = PH_SEARCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    push   = 1'b0;
    kind   = CMD_DATA;
    closed = 1'b0;
    unique case (phase_q)
      PH_NODE: begin
        if (b == CHAR_S) begin
          push = 1'b1;
          kind = CMD_CLEAR;
        end
      end
      PH_FIRST: begin
        push = 1'b1;
        kind = (b == CHAR_COMMA) ? CMD_EMIT : CMD_DATA;
      end
      PH_LIST: begin
        push = 1'b1;
        if (b == CHAR_COMMA) begin
          kind = CMD_EMIT;
        end else if (b == CHAR_CLOSE) begin
          kind   = CMD_EMIT;
          closed = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    // end of response: everything but an emit collapses to a clear
    if (in_item_i.final_byte && !(push && kind == CMD_EMIT)) begin
      push = 1'b1;
      kind = CMD_CLEAR;
    end
  end

  assign cmd_valid_o    = in_valid_i && push;
  assign cmd_o.kind     = kind;
  assign cmd_o.closed   = closed;
  assign cmd_o.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign cmd_o.is_blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  assign cmd_o.digit    = 4'(b - CHAR_ZERO);

endmodule

`default_nettype wire

FILE: rtl/jnle_queue.sv
// Short command queue between front end and back end. Register based,
// one push and one pop per cycle, a push unless full and a pop unless empty. Depends on jnle_pkg.
`default_nettype none

module jnle_queue import jnle_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      ready_o,
  input  wire cmd_t cmd_i,
  output logic      valid_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o
);

  cmd_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign ready_o = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jnle_back.sv
// Back end: token accumulator with saturation and the result register.
// Executes commands from the queue. Depends on jnle_pkg.
`default_nettype none

module jnle_back import jnle_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  input  wire cmd_t cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [PROD_W-1:0] MAX_EXT = PROD_W'({ID_BITS{1'b1}});

  tok_e               tok_q, tok_d;
  logic [ID_BITS-1:0] acc_q, acc_d;
  logic               sat_q, sat_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [PROD_W-1:0]  acc_ext, next_val;
  logic               overflow;
  logic               take_digit;
  logic               fire;

  assign acc_ext  = PROD_W'(acc_q);
  assign next_val = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(cmd_i.digit);
  assign overflow = (next_val > MAX_EXT);

  assign cmd_pop_o = cmd_valid_i &&
                     (cmd_i.kind != CMD_EMIT || !out_valid_q || out_ready_i);
  assign fire       = cmd_pop_o;
  assign take_digit = fire && cmd_i.kind == CMD_DATA && tok_q != TOK_DONE &&
                      cmd_i.is_digit;

  always_comb begin
    tok_d = tok_q;
    if (fire) begin
      unique case (cmd_i.kind)
        CMD_DATA: begin
          if (tok_q != TOK_DONE) begin
            if (cmd_i.is_digit) begin
              tok_d = TOK_DIGITS;
            end else if (!(tok_q == TOK_IDLE && cmd_i.is_blank)) begin
              tok_d = TOK_DONE;
            end
          end
        end
        CMD_EMIT:  tok_d = TOK_IDLE;
        CMD_CLEAR: tok_d = TOK_IDLE;
        default:   tok_d = TOK_IDLE;
      endcase
    end
  end

  always_comb begin
    acc_d       = acc_q;
    sat_d       = sat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take_digit) begin
      if (overflow) begin
        acc_d = {ID_BITS{1'b1}};
        sat_d = 1'b1;
      end else begin
        acc_d = next_val[ID_BITS-1:0];
      end
    end else if (fire && cmd_i.kind != CMD_DATA) begin
      acc_d = '0;
      sat_d = 1'b0;
    end
    if (fire && cmd_i.kind == CMD_EMIT) begin
      out_valid_d           = 1'b1;
      out_d.node_number     = NODE_W'(acc_q);
      out_d.list_closed     = cmd_i.closed;
      out_d.value_saturated = sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= TOK_IDLE;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tok_q       <= tok_d;
      acc_q       <= acc_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/json_node_list_extractor.sv
// Node list extractor top level: front end, command queue and back end.
// Depends on jnle_pkg, jnle_front, jnle_queue and jnle_back.
//
// Usage: feed response text on the input channel, one byte per transfer,
// with final_byte set on the last byte of a response. After the keyword
// "nodes" and three skipped bytes, the list is split on commas; each entry
// leaves on the output channel as a decimal value with list_closed set on
// the entry ended by the closing bracket and value_saturated set when the
// digits overran the value range.
// Throughput: one byte per cycle while the command queue is not full. The
// front end classifies a byte in the cycle it is accepted; the back end runs
// one command per cycle unless an emit waits on a held result. A comma or
// bracket byte is queued as an emit, then written to the result register.
// Reset: all state returns to keyword search, queue and result are empty.
// Receiver stall: the result register holds; the four-entry command queue
// keeps taking bytes until full, then in_ready_o drops for every byte,
// including bytes that produce no command, until the queue has room again.
`default_nettype none

module json_node_list_extractor import jnle_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic front_valid, queue_ready;
  logic queue_valid, queue_pop;
  cmd_t front_cmd, queue_cmd;

  jnle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (queue_ready),
    .cmd_o       (front_cmd)
  );

  jnle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .cmd_i   (front_cmd),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .cmd_o   (queue_cmd)
  );

  jnle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_pop_o   (queue_pop),
    .cmd_i       (queue_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
